// File: sv/bsds_pkg.sv
// ----------------------------------------------------------------------------
// bsds_pkg
// Shared types and constants for the brush stroke dab spacer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsds_pkg;

    localparam int POS_W         = 20;
    localparam int REG_W         = 10;
    localparam int CMD_W         = 2;
    localparam int AX_W          = 20;   // magnitude of a 21-bit difference
    localparam int PROD_W        = 2 * REG_W;
    localparam int D2_W          = 2 * AX_W + 1;
    localparam int RAD_W         = 55;   // 10000 * d2 stays below 2^55
    localparam int ROOT_W        = 28;
    localparam int CNT_W         = 5;
    localparam int SCALE_VAL     = 10000;
    localparam int P_MIN_VAL     = 100;
    localparam int MAX_DABS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 4;
    localparam int QUEUE_DEPTH   = 2;
    localparam int CFG_AW        = 1;

    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

    localparam logic [CFG_AW-1:0] REG_BRUSH_SIZE = 1'b0;
    localparam logic [CFG_AW-1:0] REG_SPACING    = 1'b1;

    typedef struct packed {
        logic             single;
        logic [POS_W-1:0] from_x;
        logic [POS_W-1:0] from_y;
        logic [POS_W-1:0] to_x;
        logic [POS_W-1:0] to_y;
    } t_job;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
        logic             cap;
    } t_dab;

endpackage

`default_nettype wire

// File: sv/brush_stroke_dab_spacer_unit.sv
// ----------------------------------------------------------------------------
// brush_stroke_dab_spacer_unit
// Turns pointer items into evenly spaced brush dab centres.
//
//   channel  dir  handshake                        payload
//   s_axis   in   i_s_axis_tvalid/o_s_axis_tready  tdata {pos_y,pos_x}, tuser {layer,btn,cmd}
//   m_axis   out  o_m_axis_tvalid/i_m_axis_tready  tdata {dab_y,dab_x}, tlast, tuser capped
//   cfg      in   i_cfg_we                         i_cfg_addr, i_cfg_wdata
//
// Press: its dab comes straight from the queued job. Move: the first dab follows
// the 28-step root loop, the step-count divide (skipped when the count
// saturates at the first check) and the 20-step offset divide, then one dab per
// cycle while the output is not stalled.
// Up to two jobs queue behind the back end; the input stalls when full.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module brush_stroke_dab_spacer_unit import bsds_pkg::*; #(
    parameter int MAX_DABS  = MAX_DABS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [2*POS_W-1:0]  i_s_axis_tdata,  // pos_x, pos_y
    input  wire logic [CMD_W+1:0]    i_s_axis_tuser,  // command, button_ok, layer_ok
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    output logic [2*POS_W-1:0]       o_m_axis_tdata,  // dab_x, dab_y
    output logic                     o_m_axis_tlast,
    output logic [0:0]               o_m_axis_tuser,  // capped
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [REG_W-1:0]    i_cfg_wdata
);

    logic [REG_W-1:0] r_brush_size, r_spacing;
    logic             q_ready, push, job_valid, job_ready;
    t_job             push_job, job;
    t_dab             dab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brush_size <= REG_W'(10);
            r_spacing    <= REG_W'(25);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_BRUSH_SIZE: r_brush_size <= i_cfg_wdata;
                REG_SPACING:    r_spacing    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    bsds_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_command   (i_s_axis_tuser[CMD_W-1:0]),
        .i_pos_x     (i_s_axis_tdata[POS_W-1:0]),
        .i_pos_y     (i_s_axis_tdata[2*POS_W-1:POS_W]),
        .i_button_ok (i_s_axis_tuser[CMD_W]),
        .i_layer_ok  (i_s_axis_tuser[CMD_W+1]),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_job       (push_job)
    );

    bsds_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_ready (q_ready),
        .o_valid (job_valid),
        .o_data  (job),
        .i_pop   (job_ready)
    );

    bsds_back #(.MAX_DABS(MAX_DABS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_brush_size (r_brush_size),
        .i_spacing    (r_spacing),
        .i_job_valid  (job_valid),
        .i_job        (job),
        .o_job_ready  (job_ready),
        .o_dab_valid  (o_m_axis_tvalid),
        .o_dab        (dab),
        .i_dab_ready  (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {dab.y, dab.x};
    assign o_m_axis_tlast = dab.last;
    assign o_m_axis_tuser = dab.cap;

endmodule

`default_nettype wire

// File: sv/bsds_front.sv
// ----------------------------------------------------------------------------
// bsds_front
// Accepts pointer items, tracks stroke state and queues dab jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module bsds_front import bsds_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [CMD_W-1:0] i_command,
    input  wire logic [POS_W-1:0] i_pos_x,
    input  wire logic [POS_W-1:0] i_pos_y,
    input  wire logic             i_button_ok,
    input  wire logic             i_layer_ok,
    input  wire logic             i_q_ready,
    output logic                  o_push,
    output t_job                  o_job
);

    logic             r_drawing, n_drawing;
    logic [POS_W-1:0] r_last_x, n_last_x;
    logic [POS_W-1:0] r_last_y, n_last_y;
    logic             accept, press_ok, move_ok;

    assign o_ready  = i_q_ready;
    assign accept   = i_valid && i_q_ready;
    assign press_ok = (i_command == CMD_PRESS) && i_button_ok && i_layer_ok;
    assign move_ok  = (i_command == CMD_MOVE) && r_drawing && i_layer_ok;
    assign o_push   = accept && (press_ok || move_ok);

    always_comb begin
        o_job.single = press_ok;
        o_job.from_x = press_ok ? i_pos_x : r_last_x;
        o_job.from_y = press_ok ? i_pos_y : r_last_y;
        o_job.to_x   = i_pos_x;
        o_job.to_y   = i_pos_y;
    end

    always_comb begin
        n_drawing = r_drawing;
        n_last_x  = r_last_x;
        n_last_y  = r_last_y;
        if (accept) begin
            unique case (i_command)
                CMD_PRESS: begin
                    if (press_ok) begin
                        n_drawing = 1'b1;
                        n_last_x  = i_pos_x;
                        n_last_y  = i_pos_y;
                    end
                end
                CMD_MOVE: begin
                    if (move_ok) begin
                        n_last_x = i_pos_x;
                        n_last_y = i_pos_y;
                    end
                end
                CMD_RELEASE: begin
                    n_drawing = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drawing <= 1'b0;
            r_last_x  <= '0;
            r_last_y  <= '0;
        end else begin
            r_drawing <= n_drawing;
            r_last_x  <= n_last_x;
            r_last_y  <= n_last_y;
        end
    end

endmodule

`default_nettype wire

// File: sv/bsds_fifo.sv
// ----------------------------------------------------------------------------
// bsds_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module bsds_fifo import bsds_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_data,
    output logic      o_ready,
    output logic      o_valid,
    output t_job      o_data,
    input  wire logic i_pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: sv/bsds_back.sv
// ----------------------------------------------------------------------------
// bsds_back
// Works out a move's step count by square root and division; emits the dabs.
// ----------------------------------------------------------------------------
`default_nettype none

module bsds_back import bsds_pkg::*; #(
    parameter int MAX_DABS  = MAX_DABS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [REG_W-1:0] i_brush_size,
    input  wire logic [REG_W-1:0] i_spacing,
    input  wire logic             i_job_valid,
    input  t_job                  i_job,
    output logic                  o_job_ready,
    output logic                  o_dab_valid,
    output t_dab                  o_dab,
    input  wire logic             i_dab_ready
);

    localparam int QW    = $clog2(MAX_DABS + 1);
    localparam int NW    = QW;
    localparam int RW    = NW + 2;
    localparam int DIV_W = PROD_W + FRAC_BITS;
    localparam int CW    = (DIV_W + QW > ROOT_W) ? DIV_W + QW : ROOT_W;

    localparam logic [RAD_W-1:0]  SCALE  = RAD_W'(SCALE_VAL);
    localparam logic [PROD_W-1:0] P_MIN  = PROD_W'(P_MIN_VAL);
    localparam logic [NW-1:0]     N_MAX  = NW'(MAX_DABS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_SCALE = 3'd2;
    localparam logic [2:0] ST_SQRT  = 3'd3;
    localparam logic [2:0] ST_QCHK  = 3'd4;
    localparam logic [2:0] ST_QDIV  = 3'd5;
    localparam logic [2:0] ST_ADIV  = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    logic [2:0]        r_st, n_st;
    logic [POS_W-1:0]  r_fx, n_fx, r_fy, n_fy;
    logic [AX_W-1:0]   r_ax, n_ax, r_ay, n_ay;
    logic              r_negx, n_negx, r_negy, n_negy;
    logic [D2_W-1:0]   r_d2, n_d2;
    logic [PROD_W-1:0] r_p, n_p;
    logic [RAD_W-1:0]  r_rad, n_rad, r_root, n_root, r_bit, n_bit;
    logic [CW-1:0]     r_rem, n_rem, r_dv, n_dv;
    logic [QW-1:0]     r_q, n_q;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [NW-1:0]     r_n, n_n, r_idx, n_idx;
    logic              r_cap, n_cap;
    logic [NW-1:0]     r_remx, n_remx, r_remy, n_remy;
    logic [RW-1:0]     r_rx, n_rx, r_ry, n_ry;
    logic [AX_W-1:0]   r_qx, n_qx, r_qy, n_qy;
    logic              r_out_valid, n_out_valid;
    t_dab              r_out, n_out;

    logic [POS_W:0]    dx, dy;
    logic [2*AX_W-1:0] sq_x, sq_y;
    logic [PROD_W-1:0] prod;
    logic [RAD_W-1:0]  trial;
    logic [DIV_W-1:0]  divisor;
    logic [QW-1:0]     q_fin;
    logic              q_ge;
    logic [NW:0]       ax_rem2, ay_rem2;
    logic              gx, gy;
    logic [RW-1:0]     two_n, sum_x, sum_y;
    logic              wrap_x, wrap_y;
    logic [AX_W-1:0]   qx_nx, qy_nx;
    logic              out_free;

    assign o_job_ready = (r_st == ST_IDLE);
    assign o_dab_valid = r_out_valid;
    assign o_dab       = r_out;
    assign out_free    = !r_out_valid || i_dab_ready;

    always_comb begin
        dx      = {i_job.to_x[POS_W-1], i_job.to_x} - {i_job.from_x[POS_W-1], i_job.from_x};
        dy      = {i_job.to_y[POS_W-1], i_job.to_y} - {i_job.from_y[POS_W-1], i_job.from_y};
        sq_x    = r_ax * r_ax;
        sq_y    = r_ay * r_ay;
        prod    = i_brush_size * i_spacing;
        trial   = r_root + r_bit;
        divisor = DIV_W'(r_p) << FRAC_BITS;
        q_ge    = (r_rem >= r_dv);
        q_fin   = QW'({r_q, q_ge});
        ax_rem2 = {r_remx, r_ax[AX_W-1]};
        ay_rem2 = {r_remy, r_ay[AX_W-1]};
        gx      = (ax_rem2 >= {1'b0, r_n});
        gy      = (ay_rem2 >= {1'b0, r_n});
        two_n   = RW'({r_n, 1'b0});
        sum_x   = r_rx + RW'({r_remx, 1'b0});
        sum_y   = r_ry + RW'({r_remy, 1'b0});
        wrap_x  = (sum_x >= two_n);
        wrap_y  = (sum_y >= two_n);
        qx_nx   = r_qx + r_ax + AX_W'(wrap_x);
        qy_nx   = r_qy + r_ay + AX_W'(wrap_y);
    end

    always_comb begin
        n_st = r_st;   n_fx = r_fx;   n_fy = r_fy;   n_ax = r_ax;   n_ay = r_ay;
        n_negx = r_negx; n_negy = r_negy; n_d2 = r_d2; n_p = r_p;
        n_rad = r_rad; n_root = r_root; n_bit = r_bit; n_rem = r_rem; n_dv = r_dv;
        n_q = r_q;     n_cnt = r_cnt; n_n = r_n;     n_idx = r_idx; n_cap = r_cap;
        n_remx = r_remx; n_remy = r_remy; n_rx = r_rx; n_ry = r_ry;
        n_qx = r_qx;   n_qy = r_qy;
        n_out_valid = r_out_valid && !i_dab_ready;
        n_out = r_out;
        unique case (r_st)
            ST_IDLE: begin
                if (i_job_valid) begin
                    if (i_job.single) begin
                        n_fx = i_job.to_x;  n_fy = i_job.to_y;
                        n_ax = '0;          n_ay = '0;
                        n_negx = 1'b0;      n_negy = 1'b0;
                        n_remx = '0;        n_remy = '0;
                        n_n = NW'(1);       n_idx = NW'(1);
                        n_rx = RW'(1);      n_ry = RW'(1);
                        n_qx = '0;          n_qy = '0;
                        n_cap = 1'b0;
                        n_st = ST_EMIT;
                    end else begin
                        n_fx = i_job.from_x; n_fy = i_job.from_y;
                        n_negx = dx[POS_W];  n_negy = dy[POS_W];
                        n_ax = dx[POS_W] ? AX_W'(-dx) : AX_W'(dx);
                        n_ay = dy[POS_W] ? AX_W'(-dy) : AX_W'(dy);
                        n_st = ST_SQ;
                    end
                end
            end
            ST_SQ: begin
                n_d2 = {1'b0, sq_x} + {1'b0, sq_y};
                n_p  = (prod < P_MIN) ? P_MIN : prod;
                n_st = ST_SCALE;
            end
            ST_SCALE: begin
                n_rad  = RAD_W'(r_d2) * SCALE;
                n_root = '0;
                n_bit  = RAD_W'(1) << (RAD_W - 1);
                n_st   = ST_SQRT;
            end
            ST_SQRT: begin
                if (r_rad >= trial) begin
                    n_rad  = r_rad - trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_st = ST_QCHK;
                end
            end
            ST_QCHK: begin
                n_cnt = '0;
                if (CW'(r_root[ROOT_W-1:0]) >= (CW'(divisor) << QW)) begin
                    n_n    = N_MAX;
                    n_cap  = 1'b1;
                    n_remx = '0;
                    n_remy = '0;
                    n_st   = ST_ADIV;
                end else begin
                    n_rem = CW'(r_root[ROOT_W-1:0]);
                    n_dv  = CW'(divisor) << (QW - 1);
                    n_q   = '0;
                    n_st  = ST_QDIV;
                end
            end
            ST_QDIV: begin
                if (q_ge) begin
                    n_rem = r_rem - r_dv;
                end
                n_dv  = r_dv >> 1;
                n_q   = q_fin;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QW - 1)) begin
                    n_cnt  = '0;
                    n_remx = '0;
                    n_remy = '0;
                    n_cap  = 1'b0;
                    if (q_fin == '0) begin
                        n_n = NW'(1);
                    end else if (q_fin > QW'(MAX_DABS)) begin
                        n_n   = N_MAX;
                        n_cap = 1'b1;
                    end else begin
                        n_n = q_fin;
                    end
                    n_st = ST_ADIV;
                end
            end
            ST_ADIV: begin
                n_remx = gx ? NW'(ax_rem2 - {1'b0, r_n}) : NW'(ax_rem2);
                n_remy = gy ? NW'(ay_rem2 - {1'b0, r_n}) : NW'(ay_rem2);
                n_ax   = {r_ax[AX_W-2:0], gx};
                n_ay   = {r_ay[AX_W-2:0], gy};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(AX_W - 1)) begin
                    n_rx  = RW'(r_n);
                    n_ry  = RW'(r_n);
                    n_qx  = '0;
                    n_qy  = '0;
                    n_idx = NW'(1);
                    n_st  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_rx = wrap_x ? sum_x - two_n : sum_x;
                    n_ry = wrap_y ? sum_y - two_n : sum_y;
                    n_qx = qx_nx;
                    n_qy = qy_nx;
                    n_out.x    = r_fx + (r_negx ? (~qx_nx + 1'b1) : qx_nx);
                    n_out.y    = r_fy + (r_negy ? (~qy_nx + 1'b1) : qy_nx);
                    n_out.last = (r_idx == r_n);
                    n_out.cap  = r_cap;
                    n_out_valid = 1'b1;
                    n_idx = r_idx + 1'b1;
                    if (r_idx == r_n) begin
                        n_st = ST_IDLE;
                    end
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_fx <= n_fx;     r_fy <= n_fy;     r_ax <= n_ax;     r_ay <= n_ay;
        r_negx <= n_negx; r_negy <= n_negy; r_d2 <= n_d2;     r_p <= n_p;
        r_rad <= n_rad;   r_root <= n_root; r_bit <= n_bit;   r_rem <= n_rem;
        r_dv <= n_dv;     r_q <= n_q;       r_n <= n_n;       r_idx <= n_idx;
        r_cap <= n_cap;   r_remx <= n_remx; r_remy <= n_remy; r_rx <= n_rx;
        r_ry <= n_ry;     r_qx <= n_qx;     r_qy <= n_qy;     r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT) |-> (r_n != '0 && r_n <= N_MAX && r_idx <= r_n))
        else $error("dab count out of range");

    a_emit_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT) |-> (r_rx < two_n && r_ry < two_n))
        else $error("interpolation remainder out of range");

    a_cap_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT && r_cap) |-> (r_n == N_MAX))
        else $error("capped run without full dab count");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_SQRT) |-> $onehot(r_bit))
        else $error("root trial bit lost");

endmodule

`default_nettype wire
